// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every rising clk edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: hw/rtl/glcm_pkg.sv
// shared types and constants for the gcd / lcm unit
// no dependencies
package glcm_pkg;

  localparam int IN_BITS   = 32;
  localparam int DIV_BITS  = 32;
  localparam int MUL_BITS  = 63;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 96;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic gcd_finish;
    logic div_step;
    logic mul_step;
    logic out_load;
  } glcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic gcd_done;
    logic cnt_last;
  } glcm_status_t;

endpackage

// File: hw/rtl/glcm_ctrl.sv
// controller state machine for the gcd / lcm unit
// depends on glcm_pkg
module glcm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  glcm_pkg::glcm_status_t status,
  output glcm_pkg::glcm_cmd_t    cmd
);
  import glcm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIV, S_MUL, S_DONE} state_t;

  state_t state, state_next;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (status.gcd_done) begin
          cmd.gcd_finish = 1'b1;
          state_next     = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.cnt_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.cnt_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/glcm_dp.sv
// datapath: binary gcd, shift-subtract divider and shift-add multiplier
// depends on glcm_pkg
module glcm_dp #(
  parameter int WIDTH = 32
) (
  input  logic                            clk,
  input  logic [glcm_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic [glcm_pkg::M_TDATA_W-1:0]  m_tdata,
  input  glcm_pkg::glcm_cmd_t             cmd,
  output glcm_pkg::glcm_status_t          status
);
  import glcm_pkg::*;

  localparam int KW = $clog2(WIDTH);
  localparam int CW = $clog2(WIDTH);
  localparam int PW = 2 * WIDTH;

  logic [WIDTH-1:0]    op_a, op_b, in_mag_a, in_mag_b;
  logic [WIDTH-1:0]    ua, ub, mag_a, mag_b, g;
  logic [KW-1:0]       k;
  logic [WIDTH-1:0]    rem, quo, hi;
  logic [CW-1:0]       cnt;
  logic [WIDTH:0]      diff_ab, diff_ba, trial, sum;
  logic [PW-1:0]       prod;
  logic [MUL_BITS-1:0] mul_res;
  logic [DIV_BITS-1:0] div_out;
  logic [MUL_BITS-1:0] mul_out;

  // operand is the low WIDTH bits of the field, zero-extended when wider
  assign op_a     = WIDTH'(s_tdata[IN_BITS-1:0]);
  assign op_b     = WIDTH'(s_tdata[2*IN_BITS-1:IN_BITS]);
  assign in_mag_a = op_a[WIDTH-1] ? (~op_a + WIDTH'(1)) : op_a;
  assign in_mag_b = op_b[WIDTH-1] ? (~op_b + WIDTH'(1)) : op_b;

  assign diff_ab = {1'b0, ua} - {1'b0, ub};
  assign diff_ba = {1'b0, ub} - {1'b0, ua};
  assign trial   = {rem, quo[WIDTH-1]} - {1'b0, g};
  assign sum     = {1'b0, hi} + (quo[0] ? {1'b0, mag_b} : '0);
  assign prod    = {hi, quo};

  generate
    if (PW > MUL_BITS) begin : g_sat
      assign mul_res = (|prod[PW-1:MUL_BITS]) ? '1 : prod[MUL_BITS-1:0];
    end else begin : g_nosat
      assign mul_res = MUL_BITS'(prod);
    end
  endgenerate

  assign status.gcd_done = (ua == '0) || (ub == '0);
  assign status.cnt_last = (cnt == CW'(WIDTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ua    <= in_mag_a;
      ub    <= in_mag_b;
      mag_a <= in_mag_a;
      mag_b <= in_mag_b;
      k     <= '0;
    end
    if (cmd.gcd_step) begin
      case ({ua[0], ub[0]})
        2'b00: begin
          ua <= ua >> 1;
          ub <= ub >> 1;
          k  <= k + 1'b1;
        end
        2'b01: ua <= ua >> 1;
        2'b10: ub <= ub >> 1;
        default: begin
          // both odd: the difference is even, halve it at once
          if (!diff_ab[WIDTH]) begin
            ua <= diff_ab[WIDTH:1];
          end else begin
            ub <= diff_ba[WIDTH:1];
          end
        end
      endcase
    end
    if (cmd.gcd_finish) begin
      g   <= (ua | ub) << k;
      rem <= '0;
      quo <= mag_a;
      hi  <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[WIDTH]) begin
        rem <= trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[WIDTH-2:0], quo[WIDTH-1]};
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.mul_step) begin
      // quotient bits leave at the bottom, product bits enter at the top
      hi  <= sum[WIDTH:1];
      quo <= {sum[0], quo[WIDTH-1:1]};
    end
    if (cmd.div_step || cmd.mul_step) begin
      cnt <= status.cnt_last ? '0 : cnt + 1'b1;
    end
    if (cmd.out_load) begin
      div_out <= DIV_BITS'(g);
      mul_out <= (g == '0) ? '0 : mul_res;
    end
  end

  assign m_tdata = {1'b0, mul_out, div_out};

endmodule

// File: hw/rtl/gcd_lcm_unit.sv
// gcd / lcm unit: one result per request, one request in flight at a time.
// from accept to m_tvalid: the load, G binary gcd steps (G at most 2*WIDTH),
// the gcd finish, then WIDTH divider and WIDTH multiplier steps, and the
// output load, which waits while the output register still holds a result.
// a new request can be taken from the same cycle that m_tvalid rises for the previous result.
// synchronous reset returns the controller to idle and clears m_tvalid.
module gcd_lcm_unit #(
  parameter int WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] first_value, [63:32] second_value
  input  logic [glcm_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] divisor_value, [94:32] multiple_value, [95] zero
  output logic [glcm_pkg::M_TDATA_W-1:0] m_tdata
);
  import glcm_pkg::*;

  glcm_cmd_t    cmd;
  glcm_status_t status;

  glcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  glcm_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk     (clk),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

// File: hw/rtl/glcm_checker.sv
// port-level checks for the gcd / lcm unit, bound to the top level
// depends on glcm_pkg and assert_macros.svh
`include "assert_macros.svh"

module glcm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [glcm_pkg::M_TDATA_W-1:0] m_tdata
);
  import glcm_pkg::*;

  // nothing left valid out of reset
  `ASSERT_CLK_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid)
  // a stalled result holds
  `ASSERT_CLK(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
  // one request at a time: busy right after accepting
  `ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready)
  // zero divisor means both operands were zero, so the multiple is zero
  `ASSERT_CLK(a_zero_gcd_zero_lcm, (m_tvalid && (m_tdata[31:0] == '0)) |-> (m_tdata[94:32] == '0))

endmodule

bind gcd_lcm_unit glcm_checker u_glcm_checker (.*);
